@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker of the translator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TLBPT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("translator check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TLBPT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("translator check failed");

`endif

@@ rtl/tlbpt_pkg.sv @@
// Shared types, constants and helpers of the TLB and page-table translator.
package tlbpt_pkg;

	localparam int PAGE_NUM_W = 8;
	localparam int OFFSET_W   = 8;
	localparam int ADDR_W     = 16;
	// Number of distinct values an 8-bit page number or offset can take.
	localparam int FIELD_SPAN = 256;

	localparam int DEF_TLB_ENTRIES = 16;
	localparam int DEF_PAGE_COUNT  = 256;
	localparam int DEF_FRAME_COUNT = 256;
	localparam int DEF_PAGE_BYTES  = 256;

	typedef struct packed {
		logic [PAGE_NUM_W-1:0] page_number;
		logic [OFFSET_W-1:0]   page_offset;
	} in_item_t;

	typedef struct packed {
		logic [ADDR_W-1:0] physical_address;
		logic              tlb_hit;
		logic              page_fault;
		logic              out_of_frames;
	} out_item_t;

	// Reduce an 8-bit value modulo a constant of at least 16: the quotient
	// stays below 16, so four conditional subtracts of shifted copies do it.
	function automatic logic [PAGE_NUM_W-1:0] reduce_mod(
		input logic [PAGE_NUM_W-1:0] value,
		input int                    modulus
	);
		int rem;
		rem = int'(value);
		for (int k = 3; k >= 0; k--) begin
			if (rem >= (modulus << k)) begin
				rem = rem - (modulus << k);
			end
		end
		return PAGE_NUM_W'(rem);
	endfunction

endpackage

@@ rtl/tlb_page_table_translator_top.sv @@
// Top level of the TLB and page-table address translator with demand paging.
//
// Channels: req carries a page number and a byte offset (req_valid/req_stall);
// rsp carries the physical address and the hit, fault and out-of-frames flags
// (rsp_valid/rsp_stall). An item moves when valid is high and stall is low.
// Flow: an accepted item enters the decide stage and its page-table RAM read
// is registered; the decide stage compares the TLB, decides, writes the RAM
// back and registers the result in the output register once that register
// is free. A new item is not accepted while one sits in the decide stage,
// so a read always sees the previous write and no forwarding is needed.
// Stall: a stalled result holds in the output register; the item behind it
// holds in the decide stage, commits no state, and req_stall stays high.
// Reset: TLB entries and page residency bits clear at once, the fill pointer
// and free-frame counter go to zero; frame RAM contents are only read for
// resident pages, so they need no clearing pass.
module tlb_page_table_translator_top import tlbpt_pkg::*; #(
	parameter int TLB_ENTRIES = DEF_TLB_ENTRIES,
	parameter int PAGE_COUNT  = DEF_PAGE_COUNT,
	parameter int FRAME_COUNT = DEF_FRAME_COUNT,
	parameter int PAGE_BYTES  = DEF_PAGE_BYTES
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  in_item_t  req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output out_item_t rsp
);

	// Only pages an 8-bit page number can reach are stored.
	localparam int PAGE_DEPTH = (PAGE_COUNT < FIELD_SPAN) ? PAGE_COUNT : FIELD_SPAN;
	localparam int PAGE_W     = $clog2(PAGE_DEPTH);
	localparam int BYTE_SPAN  = (PAGE_BYTES < FIELD_SPAN) ? PAGE_BYTES : FIELD_SPAN;
	localparam int OFS_W      = $clog2(BYTE_SPAN);
	localparam int FRAME_W    = $clog2(FRAME_COUNT);
	localparam int NFF_W      = $clog2(FRAME_COUNT + 1);

	// Stage 1: item in the decide stage.
	logic               s1_valid_q;
	logic [PAGE_W-1:0]  page_s1;
	logic [OFS_W-1:0]   offset_s1;

	// Page table: frame RAM plus residency bits in flops.
	logic [FRAME_W-1:0]    table_frames_mem [PAGE_DEPTH];
	logic [FRAME_W-1:0]    tbl_rdata_q;
	logic [PAGE_DEPTH-1:0] page_valid_q;
	logic [NFF_W-1:0]      next_free_q;

	// Output register.
	logic               rsp_valid_q;
	logic [FRAME_W-1:0] rsp_frame_q;
	logic [OFS_W-1:0]   rsp_offset_q;
	logic               rsp_hit_q;
	logic               rsp_fault_q;
	logic               rsp_oof_q;

	logic               accept;
	logic               commit;
	logic [PAGE_W-1:0]  req_page;
	logic [OFS_W-1:0]   req_offset;
	logic               tlb_hit;
	logic [FRAME_W-1:0] tlb_frame;
	logic               page_resident;
	logic               frames_used_up;
	logic               do_fault;
	logic               do_oof;
	logic               fill_en;
	logic [FRAME_W-1:0] sel_frame;
	logic [31:0]        addr_full;

	assign req_stall = s1_valid_q;
	assign accept    = req_valid && !s1_valid_q;
	assign commit    = s1_valid_q && (!rsp_valid_q || !rsp_stall);

	assign req_page   = PAGE_W'(reduce_mod(req.page_number, PAGE_COUNT));
	assign req_offset = OFS_W'(reduce_mod(req.page_offset, PAGE_BYTES));

	tlbpt_tlb #(
		.ENTRIES (TLB_ENTRIES),
		.TAG_W   (PAGE_W),
		.FRAME_W (FRAME_W)
	) u_tlb (
		.clk         (clk),
		.arst_n      (arst_n),
		.lookup_page (page_s1),
		.hit         (tlb_hit),
		.hit_frame   (tlb_frame),
		.fill_en     (fill_en),
		.fill_page   (page_s1),
		.fill_frame  (sel_frame)
	);

	// Decide: TLB hit, page-table hit, fault with a free frame, or no frame left.
	always_comb begin
		page_resident  = page_valid_q[page_s1];
		frames_used_up = (next_free_q == NFF_W'(FRAME_COUNT));
		do_fault       = !tlb_hit && !page_resident && !frames_used_up;
		do_oof         = !tlb_hit && !page_resident && frames_used_up;
		fill_en        = commit && !tlb_hit && !do_oof;
		if (tlb_hit) begin
			sel_frame = tlb_frame;
		end else if (page_resident) begin
			sel_frame = tbl_rdata_q;
		end else if (frames_used_up) begin
			sel_frame = '0;
		end else begin
			sel_frame = next_free_q[FRAME_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q   <= 1'b0;
			rsp_valid_q  <= 1'b0;
			page_valid_q <= '0;
			next_free_q  <= '0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (commit) begin
				s1_valid_q <= 1'b0;
			end
			if (commit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			// Mark the page resident and advance the free-frame counter.
			if (commit && do_fault) begin
				page_valid_q[page_s1] <= 1'b1;
				next_free_q           <= next_free_q + 1'b1;
			end
		end
	end

	// Payload registers and the frame RAM: no reset needed.
	always_ff @(posedge clk) begin
		if (accept) begin
			page_s1     <= req_page;
			offset_s1   <= req_offset;
			tbl_rdata_q <= table_frames_mem[req_page];
		end
		if (commit && do_fault) begin
			table_frames_mem[page_s1] <= sel_frame;
		end
		if (commit) begin
			rsp_frame_q  <= sel_frame;
			rsp_offset_q <= do_oof ? '0 : offset_s1;
			rsp_hit_q    <= tlb_hit;
			rsp_fault_q  <= do_fault;
			rsp_oof_q    <= do_oof;
		end
	end

	// Frame times page size plus offset, low bits kept.
	assign addr_full = 32'(rsp_frame_q) * 32'(PAGE_BYTES) + 32'(rsp_offset_q);

	assign rsp_valid                 = rsp_valid_q;
	assign rsp.physical_address      = addr_full[ADDR_W-1:0];
	assign rsp.tlb_hit               = rsp_hit_q;
	assign rsp.page_fault            = rsp_fault_q;
	assign rsp.out_of_frames         = rsp_oof_q;

endmodule

@@ rtl/tlbpt_tlb.sv @@
// Fully associative TLB: parallel tag compare and FIFO-order refill.
module tlbpt_tlb import tlbpt_pkg::*; #(
	parameter int ENTRIES = DEF_TLB_ENTRIES,
	parameter int TAG_W   = PAGE_NUM_W,
	parameter int FRAME_W = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [TAG_W-1:0]   lookup_page,
	output logic               hit,
	output logic [FRAME_W-1:0] hit_frame,
	input  logic               fill_en,
	input  logic [TAG_W-1:0]   fill_page,
	input  logic [FRAME_W-1:0] fill_frame
);

	localparam int IDX_W = $clog2(ENTRIES);

	logic [TAG_W-1:0]   tags_q   [ENTRIES];
	logic [FRAME_W-1:0] frames_q [ENTRIES];
	logic [ENTRIES-1:0] valid_q;
	logic [IDX_W-1:0]   fill_ptr_q;

	// Lowest-numbered matching entry wins: scan downwards, last match sticks.
	always_comb begin
		hit       = 1'b0;
		hit_frame = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (valid_q[i] && (tags_q[i] == lookup_page)) begin
				hit       = 1'b1;
				hit_frame = frames_q[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			fill_ptr_q <= '0;
		end else if (fill_en) begin
			valid_q[fill_ptr_q] <= 1'b1;
			if (fill_ptr_q == IDX_W'(ENTRIES - 1)) begin
				fill_ptr_q <= '0;
			end else begin
				fill_ptr_q <= fill_ptr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fill_en) begin
			tags_q[fill_ptr_q]   <= fill_page;
			frames_q[fill_ptr_q] <= fill_frame;
		end
	end

endmodule

@@ rtl/tlbpt_checker.sv @@
// Port-level checks of the translator, bound to its top level.
`include "assert_macros.svh"

module tlbpt_checker import tlbpt_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      req_valid,
	input logic      req_stall,
	input logic      rsp_valid,
	input logic      rsp_stall,
	input out_item_t rsp
);

	// At most one of hit, fault and out-of-frames per result.
	`TLBPT_ASSERT_NOW(a_flags_exclusive, clk, arst_n, rsp_valid, $countones({rsp.tlb_hit, rsp.page_fault, rsp.out_of_frames}) <= 1)

	// Nothing is mapped when frames have run out.
	`TLBPT_ASSERT_NOW(a_oof_zero_addr, clk, arst_n, rsp_valid && rsp.out_of_frames, rsp.physical_address == '0)

	// An accepted item keeps the input side busy for the next cycle.
	`TLBPT_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, req_valid && !req_stall, req_stall)

	// A stalled result holds.
	`TLBPT_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

endmodule

bind tlb_page_table_translator_top tlbpt_checker u_tlbpt_checker (.*);

@@ tb/tlb_page_table_translator_top_tb.sv @@
// Self-checking testbench for the TLB and page-table address translator.
module tlb_page_table_translator_top_tb import tlbpt_pkg::*; ();

	localparam int TLB_SLOTS = DEF_TLB_ENTRIES;
	localparam int PAGES     = DEF_PAGE_COUNT;
	localparam int FRAMES    = DEF_FRAME_COUNT;
	localparam int PAGE_SIZE = DEF_PAGE_BYTES;

	localparam int RANDOM_ITEMS  = 1500;
	localparam int HOLD_OFF_LEN  = 80;
	localparam int DRAIN_LIMIT   = 5000;
	localparam int SETTLE_CYCLES = 8;

	// Predicts each translation and keeps the results still owed by the block.
	class xlate_scoreboard;
		logic [PAGE_NUM_W-1:0] tlb_tag [TLB_SLOTS];
		int unsigned           tlb_frame [TLB_SLOTS];
		bit                    tlb_live [TLB_SLOTS];
		int unsigned           fill_slot;
		int unsigned           frame_of_page [PAGES];
		bit                    resident [PAGES];
		int unsigned           free_frame;
		out_item_t             owed_q[$];
		int unsigned           mismatches, checked;
		int unsigned           tlb_hits, table_refills, faults, frame_shortages;

		function void clear();
			for (int i = 0; i < TLB_SLOTS; i++) begin
				tlb_tag[i]   = '0;
				tlb_frame[i] = 0;
				tlb_live[i]  = 1'b0;
			end
			for (int p = 0; p < PAGES; p++) begin
				frame_of_page[p] = 0;
				resident[p]      = 1'b0;
			end
			fill_slot  = 0;
			free_frame = 0;
			owed_q.delete();
		endfunction

		function void load_tlb(int unsigned page, int unsigned frame);
			tlb_tag[fill_slot]   = PAGE_NUM_W'(page);
			tlb_frame[fill_slot] = frame;
			tlb_live[fill_slot]  = 1'b1;
			fill_slot = (fill_slot + 1 >= TLB_SLOTS) ? 0 : fill_slot + 1;
		endfunction

		function out_item_t translate(in_item_t item);
			int unsigned page, offset, frame;
			bit          found;
			out_item_t   res;
			page   = int'(item.page_number) % PAGES;
			offset = int'(item.page_offset) % PAGE_SIZE;
			frame  = 0;
			found  = 1'b0;
			res    = '0;
			// lowest-numbered live entry wins
			for (int i = 0; i < TLB_SLOTS; i++) begin
				if (!found && tlb_live[i] && tlb_tag[i] == PAGE_NUM_W'(page)) begin
					frame = tlb_frame[i];
					found = 1'b1;
				end
			end
			if (found) begin
				res.tlb_hit = 1'b1;
				tlb_hits++;
			end else if (resident[page]) begin
				frame = frame_of_page[page];
				load_tlb(page, frame);
				table_refills++;
			end else if (free_frame >= FRAMES) begin
				res.out_of_frames = 1'b1;
				frame_shortages++;
			end else begin
				frame = free_frame;
				frame_of_page[page] = frame;
				resident[page] = 1'b1;
				free_frame++;
				load_tlb(page, frame);
				res.page_fault = 1'b1;
				faults++;
			end
			if (!res.out_of_frames) begin
				res.physical_address = ADDR_W'(frame * PAGE_SIZE + offset);
			end
			return res;
		endfunction

		function void note_request(in_item_t item);
			owed_q.push_back(translate(item));
		endfunction

		function void check_response(out_item_t got);
			out_item_t want;
			checked++;
			if (owed_q.size() == 0) begin
				$error("result with nothing owed: %h", got);
				mismatches++;
				return;
			end
			want = owed_q.pop_front();
			if (got.physical_address !== want.physical_address) begin
				$error("physical_address: expected %h, got %h",
					want.physical_address, got.physical_address);
				mismatches++;
			end
			if (got.tlb_hit !== want.tlb_hit) begin
				$error("tlb_hit: expected %b, got %b", want.tlb_hit, got.tlb_hit);
				mismatches++;
			end
			if (got.page_fault !== want.page_fault) begin
				$error("page_fault: expected %b, got %b", want.page_fault, got.page_fault);
				mismatches++;
			end
			if (got.out_of_frames !== want.out_of_frames) begin
				$error("out_of_frames: expected %b, got %b",
					want.out_of_frames, got.out_of_frames);
				mismatches++;
			end
		endfunction

		function int pending();
			return owed_q.size();
		endfunction
	endclass

	logic      clk;
	logic      arst_n    = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	in_item_t  req       = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	out_item_t rsp;

	xlate_scoreboard board = new;

	// Shared controls: idling on or off for both sides, and a one-off request
	// for the receiver to hold off long enough to back the block up.
	bit          idle_enabled   = 1'b1;
	bit          hold_off_req   = 1'b0;
	int unsigned sent_count     = 0;
	int unsigned longest_hold   = 0;

	// Pages recently sent (likely TLB hits) and every page sent so far
	// (resident, so mostly page-table refills once evicted from the TLB).
	logic [PAGE_NUM_W-1:0] recent_pages[$];
	logic [PAGE_NUM_W-1:0] seen_pages[$];
	bit                    page_seen [FIELD_SPAN];

	tlb_page_table_translator_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Hard stop well beyond the slowest correct run.
	initial begin
		#4000000;
		$display("tlb_page_table_translator_top_tb: FAIL");
		$finish;
	end

	// Offer one item, hold it steady while stalled, and log it on acceptance.
	// An optional idle burst goes in front of the item.
	task automatic send_request(input logic [PAGE_NUM_W-1:0] page,
		input logic [OFFSET_W-1:0] offset);
		in_item_t item;
		item.page_number = page;
		item.page_offset = offset;
		if (idle_enabled && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		board.note_request(item);
		sent_count++;
		recent_pages.push_back(page);
		if (recent_pages.size() > 10) begin
			void'(recent_pages.pop_front());
		end
		if (!page_seen[page]) begin
			page_seen[page] = 1'b1;
			seen_pages.push_back(page);
		end
	endtask

	// Drop valid and wait until every owed result has come back (bounded).
	task automatic wait_for_results(input int limit);
		int n;
		n = 0;
		req_valid <= 1'b0;
		do begin
			@(posedge clk);
			n++;
		end while (board.pending() != 0 && n < limit);
	endtask

	// Mostly a working set that recurs, some resident pages, some fresh ones.
	function automatic logic [PAGE_NUM_W-1:0] pick_page();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll <= 3 && recent_pages.size() > 0) begin
			return recent_pages[$urandom_range(0, recent_pages.size() - 1)];
		end
		if (roll <= 6 && seen_pages.size() > 0) begin
			return seen_pages[$urandom_range(0, seen_pages.size() - 1)];
		end
		return PAGE_NUM_W'($urandom_range(0, FIELD_SPAN - 1));
	endfunction

	// Receiver: check each accepted result, then decide the stall for the
	// next cycle. Stall in short random bursts, or for one long stretch when
	// asked, counted here in cycles.
	initial begin : result_side
		int hold;
		hold = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (rsp_valid && !rsp_stall) begin
				board.check_response(rsp);
			end
			if (hold > 0) begin
				hold--;
			end else if (hold_off_req) begin
				hold = HOLD_OFF_LEN;
				longest_hold = HOLD_OFF_LEN;
				hold_off_req = 1'b0;
			end else if (idle_enabled && $urandom_range(0, 4) == 0) begin
				hold = $urandom_range(1, 6);
			end
			rsp_stall <= (hold > 0);
		end
	end

	initial begin : stimulus
		for (int p = 0; p < FIELD_SPAN; p++) begin
			page_seen[p] = 1'b0;
		end
		board.clear();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. First touch of a page faults, a repeat hits the TLB.
		send_request(8'h00, 8'h00);
		send_request(8'h00, 8'hff);
		send_request(8'hff, 8'hff);
		send_request(8'hff, 8'h00);
		send_request(8'haa, 8'h55);
		send_request(8'h55, 8'haa);
		// Fill the remaining slots so the fill pointer wraps.
		for (int p = 8'h10; p < 8'h1c; p++) begin
			send_request(PAGE_NUM_W'(p), OFFSET_W'(p * 17));
		end
		// Fresh page evicts the oldest slot; the evicted pages then come back
		// from the page table with their own frames, and hit again after.
		send_request(8'h80, 8'h7f);
		send_request(8'h00, 8'h80);
		send_request(8'hff, 8'h01);
		send_request(8'h00, 8'hfe);
		send_request(8'haa, 8'h00);

		// Sender pause: let everything drain before the random part.
		wait_for_results(DRAIN_LIMIT);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			// Idle in three windows out of four, never in the last stretch.
			idle_enabled = ((i / 100) % 4 != 3) && (i < RANDOM_ITEMS - 300);
			if (i == 400) begin
				// Long receiver hold-off while the sender keeps offering.
				hold_off_req = 1'b1;
			end
			if (i == 800) begin
				wait_for_results(DRAIN_LIMIT);
			end
			send_request(pick_page(), OFFSET_W'($urandom_range(0, FIELD_SPAN - 1)));
		end

		wait_for_results(DRAIN_LIMIT);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (board.pending() != 0) begin
			$error("%0d results never arrived", board.pending());
			board.mismatches++;
		end

		$display("Covered %0d requests, %0d results checked: %0d TLB hits, %0d table refills,",
			sent_count, board.checked, board.tlb_hits, board.table_refills);
		$display("%0d page faults, %0d out-of-frames, %0d of %0d frames used, %0d-cycle hold-off.",
			board.faults, board.frame_shortages, board.free_frame, FRAMES, longest_hold);
		if (board.mismatches == 0) begin
			$display("tlb_page_table_translator_top_tb: PASS");
		end else begin
			$display("tlb_page_table_translator_top_tb: FAIL");
		end
		$finish;
	end

endmodule
